// ===== sv/adc_cm_pkg.sv =====
`default_nettype none

package adc_cm_pkg;

  localparam int unsigned RAW_W    = 10;
  localparam int unsigned SAMPLE_W = 11;
  localparam int unsigned CAP_W    = 8;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LENGTH = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CAP_W-1:0]    capture_t;

  // running extremes start from the largest and smallest reachable samples
  localparam sample_t MIN_RESET = 11'sd1023;
  localparam sample_t MAX_RESET = -11'sd1023;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

  typedef struct packed {
    logic    start;
    logic    med_en;
    sample_t sample;
  } sort_req_t;

  typedef struct packed {
    logic    done;
    sample_t median;
  } sort_rsp_t;

endpackage

`default_nettype wire

// ===== sv/adc_cm_sorter.sv =====
`default_nettype none

module adc_cm_sorter #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  adc_cm_pkg::sort_req_t      req_i,
  input  wire  [IDX_W-1:0]           pos_i,
  input  wire  [IDX_W-1:0]           med_idx_i,
  output adc_cm_pkg::sort_rsp_t      rsp_o
);
  import adc_cm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_HEAD,
    S_MRD,
    S_MDAT
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  k_q, k_d;
  sample_t           v_q, v_d;
  logic              med_en_q, med_en_d;
  logic [IDX_W-1:0]  med_idx_q, med_idx_d;
  logic              done_q, done_d;
  sample_t           median_q, median_d;

  // window kept in descending order, one port each way
  sample_t           mem [DEPTH];
  sample_t           rdata_q;
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  sample_t           wdata;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    v_d       = v_q;
    med_en_d  = med_en_q;
    med_idx_d = med_idx_q;
    done_d    = 1'b0;
    median_d  = median_q;
    we        = 1'b0;
    waddr     = k_q;
    wdata     = v_q;
    re        = 1'b0;
    raddr     = k_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          v_d       = req_i.sample;
          med_en_d  = req_i.med_en;
          med_idx_d = med_idx_i;
          k_d       = pos_i;
          if (pos_i == '0) begin
            we    = 1'b1;
            waddr = '0;
            wdata = req_i.sample;
            if (req_i.med_en) begin
              state_d = S_MRD;
            end else begin
              done_d   = 1'b1;
              median_d = '0;
            end
          end else begin
            re      = 1'b1;
            raddr   = pos_i - IDX_W'(1);
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = k_q;
        // rdata_q holds entry k-1
        if (rdata_q < v_q) begin
          wdata = rdata_q;
          if (k_q == IDX_W'(1)) begin
            state_d = S_HEAD;
          end else begin
            re    = 1'b1;
            raddr = k_q - IDX_W'(2);
            k_d   = k_q - IDX_W'(1);
          end
        end else begin
          wdata = v_q;
          if (med_en_q) begin
            state_d = S_MRD;
          end else begin
            done_d   = 1'b1;
            median_d = '0;
            state_d  = S_IDLE;
          end
        end
      end
      S_HEAD: begin
        we    = 1'b1;
        waddr = '0;
        wdata = v_q;
        if (med_en_q) begin
          state_d = S_MRD;
        end else begin
          done_d   = 1'b1;
          median_d = '0;
          state_d  = S_IDLE;
        end
      end
      S_MRD: begin
        re      = 1'b1;
        raddr   = med_idx_q;
        state_d = S_MDAT;
      end
      S_MDAT: begin
        done_d   = 1'b1;
        median_d = rdata_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      v_q       <= '0;
      med_en_q  <= 1'b0;
      med_idx_q <= '0;
      done_q    <= 1'b0;
      median_q  <= '0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      v_q       <= v_d;
      med_en_q  <= med_en_d;
      med_idx_q <= med_idx_d;
      done_q    <= done_d;
      median_q  <= median_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.median = median_q;

endmodule

`default_nettype wire

// ===== sv/adc_capture_median.sv =====
// Single-channel ADC capture with windowed median. Each raw conversion has
// zero_offset subtracted; the result carries the offset sample, that sample
// divided by four toward zero and clipped to a signed byte, and the running
// minimum and maximum since reset. The sample that fills a window of
// capture_length entries (0 acts as 1, values above WINDOW_DEPTH act as
// WINDOW_DEPTH) is flagged last and carries the median, the entry at index
// n/2 of the window sorted descending; median reads 0 on other items.
// One item at a time. A sample at position p of the window (0 .. WINDOW_DEPTH-1)
// is inserted into the sorted window memory by moving past m held entries
// (0 .. p), one entry moved per cycle through its single read and write port;
// the item that closes the window then also reads the median entry. The next
// request can be taken in the same cycle as the result appears. A finished
// result waits in the output register while the next sample is taken. The
// user must write registers on the cfg channel only at a time the block is
// idle; the block itself does not enforce it. cfg_ready_o is always high.

`default_nettype none

module adc_capture_median #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire  [adc_cm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [adc_cm_pkg::CFG_DAT_W-1:0]          cfg_data_i,
  input  wire                                       in_valid_i,
  output logic                                      in_stall_o,
  input  wire  [adc_cm_pkg::RAW_W-1:0]              raw_sample_i,
  output logic                                      out_valid_o,
  input  wire                                       out_stall_i,
  output logic signed [adc_cm_pkg::SAMPLE_W-1:0]    offset_sample_o,
  output logic signed [adc_cm_pkg::CAP_W-1:0]       capture_value_o,
  output logic                                      last_o,
  output logic signed [adc_cm_pkg::SAMPLE_W-1:0]    median_o,
  output logic signed [adc_cm_pkg::SAMPLE_W-1:0]    running_min_o,
  output logic signed [adc_cm_pkg::SAMPLE_W-1:0]    running_max_o
);
  import adc_cm_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SORT,
    T_HOLD
  } state_e;

  state_e              state_q, state_d;
  logic [RAW_W-1:0]    zero_off_q, zero_off_d;
  logic [LEN_W-1:0]    cap_len_q, cap_len_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  sample_t             min_q, min_d, max_q, max_d;

  sort_req_t           req_q, req_d;
  logic [IDX_W-1:0]    pos_q, pos_d, med_idx_q, med_idx_d;
  sort_rsp_t           rsp;

  // result parked while the sort runs
  sample_t             p_off_q, p_off_d;
  capture_t            p_cap_q, p_cap_d;
  logic                p_last_q, p_last_d;
  sample_t             p_med_q, p_med_d;
  sample_t             p_min_q, p_min_d, p_max_q, p_max_d;

  logic                out_valid_q, out_valid_d;
  sample_t             o_off_q, o_off_d;
  capture_t            o_cap_q, o_cap_d;
  logic                o_last_q, o_last_d;
  sample_t             o_med_q, o_med_d;
  sample_t             o_min_q, o_min_d, o_max_q, o_max_d;

  logic                in_acc, out_free;
  sample_t             v_c, v_adj, q_full;
  capture_t            cap_c;
  logic [IDX_W-1:0]    pos_c, med_idx_c;
  logic [CNT_W-1:0]    held_c, held_half;
  logic [CW-1:0]       len_ext, eff_c;
  logic                last_c;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != T_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    v_c   = $signed({1'b0, raw_sample_i}) - $signed({1'b0, zero_off_q});
    // bias negatives so the shift rounds toward zero
    v_adj = v_c[SAMPLE_W-1] ? (v_c + 11'sd3) : v_c;
    q_full = v_adj >>> 2;
    if (q_full > 11'sd127) begin
      cap_c = 8'sd127;
    end else if (q_full < -11'sd128) begin
      cap_c = -8'sd128;
    end else begin
      cap_c = q_full[CAP_W-1:0];
    end

    if (fill_q >= CNT_W'(WINDOW_DEPTH - 1)) begin
      pos_c = IDX_W'(WINDOW_DEPTH - 1);
    end else begin
      pos_c = fill_q[IDX_W-1:0];
    end
    held_c    = CNT_W'(pos_c) + CNT_W'(1);
    held_half = held_c >> 1;
    med_idx_c = held_half[IDX_W-1:0];

    len_ext = CW'(cap_len_q);
    if (cap_len_q == '0) begin
      eff_c = CW'(1);
    end else if (len_ext > CW'(WINDOW_DEPTH)) begin
      eff_c = CW'(WINDOW_DEPTH);
    end else begin
      eff_c = len_ext;
    end
    last_c = (CW'(held_c) >= eff_c);
  end

  always_comb begin
    state_d     = state_q;
    zero_off_d  = zero_off_q;
    cap_len_d   = cap_len_q;
    fill_d      = fill_q;
    min_d       = min_q;
    max_d       = max_q;
    req_d       = req_q;
    req_d.start = 1'b0;
    pos_d       = pos_q;
    med_idx_d   = med_idx_q;
    p_off_d     = p_off_q;
    p_cap_d     = p_cap_q;
    p_last_d    = p_last_q;
    p_med_d     = p_med_q;
    p_min_d     = p_min_q;
    p_max_d     = p_max_q;
    out_valid_d = out_valid_q && out_stall_i;
    o_off_d     = o_off_q;
    o_cap_d     = o_cap_q;
    o_last_d    = o_last_q;
    o_med_d     = o_med_q;
    o_min_d     = o_min_q;
    o_max_d     = o_max_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ZERO_OFFSET:    zero_off_d = cfg_data_i[RAW_W-1:0];
        REG_CAPTURE_LENGTH: cap_len_d  = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          min_d        = (v_c < min_q) ? v_c : min_q;
          max_d        = (v_c > max_q) ? v_c : max_q;
          fill_d       = last_c ? '0 : held_c;
          req_d.start  = 1'b1;
          req_d.med_en = last_c;
          req_d.sample = v_c;
          pos_d        = pos_c;
          med_idx_d    = med_idx_c;
          p_off_d      = v_c;
          p_cap_d      = cap_c;
          p_last_d     = last_c;
          p_min_d      = (v_c < min_q) ? v_c : min_q;
          p_max_d      = (v_c > max_q) ? v_c : max_q;
          state_d      = T_SORT;
        end
      end
      T_SORT: begin
        if (rsp.done) begin
          p_med_d = rsp.median;
          if (out_free) begin
            out_valid_d = 1'b1;
            o_off_d     = p_off_q;
            o_cap_d     = p_cap_q;
            o_last_d    = p_last_q;
            o_med_d     = rsp.median;
            o_min_d     = p_min_q;
            o_max_d     = p_max_q;
            state_d     = T_IDLE;
          end else begin
            state_d = T_HOLD;
          end
        end
      end
      T_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_off_d     = p_off_q;
          o_cap_d     = p_cap_q;
          o_last_d    = p_last_q;
          o_med_d     = p_med_q;
          o_min_d     = p_min_q;
          o_max_d     = p_max_q;
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      zero_off_q  <= '0;
      cap_len_q   <= LEN_RESET;
      fill_q      <= '0;
      min_q       <= MIN_RESET;
      max_q       <= MAX_RESET;
      req_q       <= '0;
      pos_q       <= '0;
      med_idx_q   <= '0;
      p_off_q     <= '0;
      p_cap_q     <= '0;
      p_last_q    <= 1'b0;
      p_med_q     <= '0;
      p_min_q     <= '0;
      p_max_q     <= '0;
      out_valid_q <= 1'b0;
      o_off_q     <= '0;
      o_cap_q     <= '0;
      o_last_q    <= 1'b0;
      o_med_q     <= '0;
      o_min_q     <= '0;
      o_max_q     <= '0;
    end else begin
      state_q     <= state_d;
      zero_off_q  <= zero_off_d;
      cap_len_q   <= cap_len_d;
      fill_q      <= fill_d;
      min_q       <= min_d;
      max_q       <= max_d;
      req_q       <= req_d;
      pos_q       <= pos_d;
      med_idx_q   <= med_idx_d;
      p_off_q     <= p_off_d;
      p_cap_q     <= p_cap_d;
      p_last_q    <= p_last_d;
      p_med_q     <= p_med_d;
      p_min_q     <= p_min_d;
      p_max_q     <= p_max_d;
      out_valid_q <= out_valid_d;
      o_off_q     <= o_off_d;
      o_cap_q     <= o_cap_d;
      o_last_q    <= o_last_d;
      o_med_q     <= o_med_d;
      o_min_q     <= o_min_d;
      o_max_q     <= o_max_d;
    end
  end

  adc_cm_sorter #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W)
  ) u_sorter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_q),
    .pos_i     (pos_q),
    .med_idx_i (med_idx_q),
    .rsp_o     (rsp)
  );

  assign out_valid_o     = out_valid_q;
  assign offset_sample_o = o_off_q;
  assign capture_value_o = o_cap_q;
  assign last_o          = o_last_q;
  assign median_o        = o_med_q;
  assign running_min_o   = o_min_q;
  assign running_max_o   = o_max_q;

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a request was still in flight");

  // the sorter only finishes while a request is being sorted
  a_done_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == T_SORT))
    else $error("sort finished with no request pending");

  // median field is zero on items that do not close a window
  a_median_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (median_o == '0))
    else $error("median set on an item that is not last");

  // extremes bracket every delivered sample
  a_min_max_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((running_min_o <= offset_sample_o)
                     && (offset_sample_o <= running_max_o)))
    else $error("running extremes do not bracket the sample");

endmodule

`default_nettype wire
